[src/assert_macros.svh]
// Assertion macros shared by the rational arithmetic unit RTL.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rar_pkg.sv]
// Package for the rational arithmetic unit: operation codes, controller
// commands, command/status structs and output field widths. No dependencies.
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam int WHOLE_W      = 34;
    localparam int FRAC_W       = 32;
    localparam int DEN_W        = 31;
    localparam int IN_USER_W    = 2;
    localparam int OUT_FIELDS_W = WHOLE_W + FRAC_W + DEN_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_COMB,
        CMD_GCD_STEP,
        CMD_GCD_FIN,
        CMD_DIVN_GO,
        CMD_DIVN_WAIT,
        CMD_DIVD_GO,
        CMD_DIVD_WAIT,
        CMD_DIVW_GO,
        CMD_DIVW_WAIT,
        CMD_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
    } t_ctl;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[src/rar_div.sv]
// Restoring divider, one quotient bit per cycle, for the rational unit.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rar_div #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DW-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = !diff[DW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CW'(DW);
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    `ASSERT_IMPLY(a_rem_below_dvs, o_done, o_rem < r_dvs, "divider remainder not below divisor")
    `ASSERT_NEXT(a_start_busy, i_start, r_busy && !r_done, "divider did not start")

endmodule

[src/rar_dp.sv]
// Datapath of the rational unit: operand load, shared multiplier, sign-magnitude
// add, binary gcd, divider and output register. Depends on rar_pkg, rar_div.
`include "assert_macros.svh"

module rar_dp
    import rar_pkg::*;
#(
    parameter int W = OPERAND_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctl                      i_ctl,
    output t_sts                      o_sts,
    input  t_func                     i_func,
    input  logic signed [W-1:0]       i_a_num,
    input  logic signed [W-1:0]       i_a_den,
    input  logic signed [W-1:0]       i_b_num,
    input  logic signed [W-1:0]       i_b_den,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [WHOLE_W-1:0] o_whole_part,
    output logic signed [FRAC_W-1:0]  o_frac_num,
    output logic [DEN_W-1:0]          o_red_den,
    output logic                      o_den_was_zero
);

    localparam int MW = 2 * W;
    localparam int KW = $clog2(MW + 1);
    localparam int OW = (MW > WHOLE_W) ? MW : WHOLE_W;

    // operands, sign-magnitude
    t_func          r_func;
    logic [W-1:0]   r_an_m, r_ad_m, r_bn_m, r_bd_m;
    logic           r_an_s, r_ad_s, r_bn_s, r_bd_s;
    // products
    logic [MW-1:0]  r_p0, r_p1, r_p2;
    logic           r_n0, r_n1, r_n2;
    // reduction
    logic [MW-1:0]  r_num, r_den, r_x, r_y, r_g, r_wm, r_fm;
    logic [KW-1:0]  r_k;
    logic           r_neg, r_flag;
    // output register
    logic                      r_out_valid;
    logic signed [WHOLE_W-1:0] r_whole;
    logic signed [FRAC_W-1:0]  r_frac;
    logic [DEN_W-1:0]          r_rden;
    logic                      r_zflag;

    logic [W-1:0]   an_m, ad_m, bn_m, bd_m;
    logic           an_s, ad_s, bn_s, bd_s;
    logic [W-1:0]   mul_a, mul_b;
    logic           mul_s;
    logic [MW-1:0]  mul_p;
    logic           n1_eff;
    logic [MW-1:0]  sum_m;
    logic           sum_s;
    logic           den_zero;
    logic [MW-1:0]  x_nx, y_nx;
    logic [KW-1:0]  k_nx;
    logic           div_start, div_done;
    logic [MW-1:0]  div_dvd, div_dvs, div_quo, div_rem;
    logic           res_neg;
    logic [OW-1:0]  wm_ext, fm_ext, dm_ext, whole_ext, frac_ext;

    // operand decode
    always_comb begin
        an_s = i_a_num[W-1];
        an_m = an_s ? unsigned'(-i_a_num) : unsigned'(i_a_num);
        bn_s = i_b_num[W-1];
        bn_m = bn_s ? unsigned'(-i_b_num) : unsigned'(i_b_num);
        if (i_a_den == '0) begin
            ad_s = 1'b0;
            ad_m = W'(1);
        end else begin
            ad_s = i_a_den[W-1];
            ad_m = ad_s ? unsigned'(-i_a_den) : unsigned'(i_a_den);
        end
        if (i_b_den == '0) begin
            bd_s = 1'b0;
            bd_m = W'(1);
        end else begin
            bd_s = i_b_den[W-1];
            bd_m = bd_s ? unsigned'(-i_b_den) : unsigned'(i_b_den);
        end
    end

    // shared multiplier
    always_comb begin
        case (i_ctl.cmd)
            CMD_MUL0: begin
                mul_a = r_an_m;
                mul_b = (r_func == FUNC_MUL) ? r_bn_m : r_bd_m;
                mul_s = r_an_s ^ ((r_func == FUNC_MUL) ? r_bn_s : r_bd_s);
            end
            CMD_MUL1: begin
                mul_a = r_bn_m;
                mul_b = r_ad_m;
                mul_s = r_bn_s ^ r_ad_s;
            end
            default: begin
                mul_a = r_ad_m;
                mul_b = (r_func == FUNC_DIV) ? r_bn_m : r_bd_m;
                mul_s = r_ad_s ^ ((r_func == FUNC_DIV) ? r_bn_s : r_bd_s);
            end
        endcase
        mul_p = MW'(mul_a) * MW'(mul_b);
    end

    // numerator combine
    always_comb begin
        n1_eff = r_n1 ^ (r_func == FUNC_SUB);
        case (r_func) inside
            FUNC_ADD, FUNC_SUB: begin
                if (r_n0 == n1_eff) begin
                    sum_m = r_p0 + r_p1;
                    sum_s = r_n0;
                end else if (r_p0 >= r_p1) begin
                    sum_m = r_p0 - r_p1;
                    sum_s = r_n0;
                end else begin
                    sum_m = r_p1 - r_p0;
                    sum_s = n1_eff;
                end
            end
            default: begin
                sum_m = r_p0;
                sum_s = r_n0;
            end
        endcase
        den_zero = (r_p2 == '0);
    end

    // binary gcd step; at least one of x, y stays odd after the common twos
    always_comb begin
        x_nx = r_x;
        y_nx = r_y;
        k_nx = r_k;
        if (r_x != '0) begin
            if (!r_x[0] && !r_y[0]) begin
                x_nx = r_x >> 1;
                y_nx = r_y >> 1;
                k_nx = r_k + 1'b1;
            end else if (!r_x[0]) begin
                x_nx = r_x >> 1;
            end else if (!r_y[0]) begin
                y_nx = r_y >> 1;
            end else if (r_x >= r_y) begin
                x_nx = (r_x - r_y) >> 1;
            end else begin
                y_nx = (r_y - r_x) >> 1;
            end
        end
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_num;
        div_dvs   = r_g;
        case (i_ctl.cmd)
            CMD_DIVN_GO: div_start = 1'b1;
            CMD_DIVD_GO: begin
                div_start = 1'b1;
                div_dvd   = r_den;
            end
            CMD_DIVW_GO: begin
                div_start = 1'b1;
                div_dvs   = r_den;
            end
            default: div_start = 1'b0;
        endcase
    end

    rar_div #(
        .DW (MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // result formatting, wrapped to the field widths
    always_comb begin
        res_neg   = (r_num != '0) && r_neg;
        wm_ext    = OW'(r_wm);
        fm_ext    = OW'(r_fm);
        dm_ext    = OW'(r_den);
        whole_ext = res_neg ? (~wm_ext + 1'b1) : wm_ext;
        frac_ext  = res_neg ? (~fm_ext + 1'b1) : fm_ext;
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_func <= i_func;
                r_an_m <= an_m;
                r_an_s <= an_s;
                r_ad_m <= ad_m;
                r_ad_s <= ad_s;
                r_bn_m <= bn_m;
                r_bn_s <= bn_s;
                r_bd_m <= bd_m;
                r_bd_s <= bd_s;
            end
            CMD_MUL0: begin
                r_p0 <= mul_p;
                r_n0 <= mul_s;
            end
            CMD_MUL1: begin
                r_p1 <= mul_p;
                r_n1 <= mul_s;
            end
            CMD_MUL2: begin
                r_p2 <= mul_p;
                r_n2 <= mul_s;
            end
            CMD_COMB: begin
                r_num  <= sum_m;
                r_den  <= den_zero ? MW'(1) : r_p2;
                r_x    <= sum_m;
                r_y    <= den_zero ? MW'(1) : r_p2;
                r_k    <= '0;
                r_neg  <= sum_s ^ (r_n2 && !den_zero);
                r_flag <= den_zero;
            end
            CMD_GCD_STEP: begin
                r_x <= x_nx;
                r_y <= y_nx;
                r_k <= k_nx;
            end
            CMD_GCD_FIN: r_g <= r_y << r_k;
            CMD_DIVN_WAIT: begin
                if (div_done) begin
                    r_num <= div_quo;
                end
            end
            CMD_DIVD_WAIT: begin
                if (div_done) begin
                    r_den <= div_quo;
                end
            end
            CMD_DIVW_WAIT: begin
                if (div_done) begin
                    r_wm <= div_quo;
                    r_fm <= div_rem;
                end
            end
            CMD_OUT: begin
                r_whole <= signed'(whole_ext[WHOLE_W-1:0]);
                r_frac  <= signed'(frac_ext[FRAC_W-1:0]);
                r_rden  <= dm_ext[DEN_W-1:0];
                r_zflag <= r_flag;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.cmd == CMD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.gcd_done  = (r_x == '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_whole_part   = r_whole;
    assign o_frac_num     = r_frac;
    assign o_red_den      = r_rden;
    assign o_den_was_zero = r_zflag;

    `ASSERT_IMPLY(a_gcd_y_nonzero, i_ctl.cmd == CMD_GCD_STEP, r_y != '0, "gcd operand y hit zero")
    `ASSERT_IMPLY(a_out_slot_free, i_ctl.cmd == CMD_OUT, !r_out_valid || i_out_ready, "output overwritten")

endmodule

[src/rar_ctrl.sv]
// Controller of the rational unit: sequences load, multiply, gcd, divides and
// output through commands to the datapath. Depends on rar_pkg.
`include "assert_macros.svh"

module rar_ctrl
    import rar_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_GCD,
        S_GFIN,
        S_DN0,
        S_DN1,
        S_DD0,
        S_DD1,
        S_DW0,
        S_DW1,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state   = r_state;
        o_ctl.cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_state   = S_MUL0;
                end
            end
            S_MUL0: begin
                o_ctl.cmd = CMD_MUL0;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_ctl.cmd = CMD_MUL1;
                n_state   = S_MUL2;
            end
            S_MUL2: begin
                o_ctl.cmd = CMD_MUL2;
                n_state   = S_COMB;
            end
            S_COMB: begin
                o_ctl.cmd = CMD_COMB;
                n_state   = S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_GFIN;
                end else begin
                    o_ctl.cmd = CMD_GCD_STEP;
                end
            end
            S_GFIN: begin
                o_ctl.cmd = CMD_GCD_FIN;
                n_state   = S_DN0;
            end
            S_DN0: begin
                o_ctl.cmd = CMD_DIVN_GO;
                n_state   = S_DN1;
            end
            S_DN1: begin
                o_ctl.cmd = CMD_DIVN_WAIT;
                if (i_sts.div_done) begin
                    n_state = S_DD0;
                end
            end
            S_DD0: begin
                o_ctl.cmd = CMD_DIVD_GO;
                n_state   = S_DD1;
            end
            S_DD1: begin
                o_ctl.cmd = CMD_DIVD_WAIT;
                if (i_sts.div_done) begin
                    n_state = S_DW0;
                end
            end
            S_DW0: begin
                o_ctl.cmd = CMD_DIVW_GO;
                n_state   = S_DW1;
            end
            S_DW1: begin
                o_ctl.cmd = CMD_DIVW_WAIT;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.cmd = CMD_OUT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

    `ASSERT_IMPLY(a_ready_in_idle, o_in_ready, r_state == S_IDLE, "ready outside idle")
    `ASSERT_NEXT(a_accept_starts, i_in_valid && o_in_ready, r_state == S_MUL0, "item not started")

endmodule

[src/rational_arith_reduce_unit.sv]
// Top level of the rational arithmetic unit with gcd reduction.
// Depends on rar_pkg, rar_ctrl, rar_dp (which holds rar_div).
//
// Usage:
//  Slave channel: i_s_tdata carries a_num, a_den, b_num, b_den (each
//  OPERAND_WIDTH bits, two's complement), i_s_tuser the operation (add, sub,
//  mul, div). An item is taken when i_s_tvalid and o_s_tready are high.
//  Master channel: o_m_tdata carries whole part, remainder numerator and
//  reduced denominator, o_m_tuser flags a zero product denominator.
//  One item is worked on at a time. The bit-serial divider, used three
//  times per item, and the binary gcd loop set the time until o_m_tvalid
//  rises; the next item is taken as soon as the result is registered.
//  A result waiting in the output register does not block the next item;
//  if the receiver still stalls when the following result is ready, the
//  block holds that result internally until the register frees.
//  Reset (synchronous, active low) clears the controller and output valid;
//  o_s_tready is high straight after reset.
module rational_arith_reduce_unit
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_tvalid,
    output logic                                      o_s_tready,
    // a_num, a_den, b_num, b_den, zero padding
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    // func
    input  logic [IN_USER_W-1:0]                      i_s_tuser,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    // whole_part, frac_num, red_den, zero padding
    output logic [OUT_TDATA_W-1:0]                    o_m_tdata,
    // den_was_zero
    output logic [0:0]                                o_m_tuser
);

    localparam int W = OPERAND_WIDTH;

    t_ctl ctl;
    t_sts sts;

    logic signed [WHOLE_W-1:0] whole_part;
    logic signed [FRAC_W-1:0]  frac_num;
    logic [DEN_W-1:0]          red_den;
    logic                      den_was_zero;

    rar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    rar_dp #(
        .W (W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_func         (t_func'(i_s_tuser)),
        .i_a_num        (signed'(i_s_tdata[W-1:0])),
        .i_a_den        (signed'(i_s_tdata[2*W-1:W])),
        .i_b_num        (signed'(i_s_tdata[3*W-1:2*W])),
        .i_b_den        (signed'(i_s_tdata[4*W-1:3*W])),
        .o_out_valid    (o_m_tvalid),
        .i_out_ready    (i_m_tready),
        .o_whole_part   (whole_part),
        .o_frac_num     (frac_num),
        .o_red_den      (red_den),
        .o_den_was_zero (den_was_zero)
    );

    assign o_m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), red_den, frac_num, whole_part};
    assign o_m_tuser = den_was_zero;

endmodule

[bench/testbench.sv]
// Self-checking bench for rational_arith_reduce_unit: directed and random fraction items,
// a clocked driver and monitor, and a mixed-number predictor with gcd reduction.
// Depends on rar_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
    import rar_pkg::*;

    localparam int OW           = OPERAND_WIDTH_DEF;
    localparam int IN_TDATA_W   = ((4*OW+7)/8)*8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_ITEMS   = 100;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 250;
    localparam int STALL_LIMIT  = 5000;

    typedef struct {
        t_func              func;
        logic signed [15:0] a_num;
        logic signed [15:0] a_den;
        logic signed [15:0] b_num;
        logic signed [15:0] b_den;
    } t_operands;

    typedef struct {
        logic signed [WHOLE_W-1:0] whole;
        logic signed [FRAC_W-1:0]  frac;
        logic [DEN_W-1:0]          den;
        logic                      den_zero;
    } t_mixed;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [IN_USER_W-1:0]   i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [0:0]             o_m_tuser;

    t_operands operand_q[$];
    t_mixed    quotient_q[$];
    int        total_ops = 0;
    int        ops_taken = 0;
    int        results_taken = 0;
    int        err_cnt = 0;
    int        quiet_cycles = 0;
    int        tx_gap = 0;
    int        rx_stall = 0;
    int        hold_left = 0;
    int        hold_stage = 0;
    logic      op_took = 1'b0;

    rational_arith_reduce_unit #(
        .OPERAND_WIDTH(OW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_mixed reduce_rational(t_operands ops);
        t_mixed r;
        longint an, ad, bn, bd, num, den, nm, dm, x, y, t;
        bit     neg;
        an = ops.a_num;
        ad = ops.a_den;
        bn = ops.b_num;
        bd = ops.b_den;
        if (ad == 0) ad = 1;
        if (bd == 0) bd = 1;
        case (ops.func)
            FUNC_ADD: begin
                num = an*bd + bn*ad;
                den = ad*bd;
            end
            FUNC_SUB: begin
                num = an*bd - bn*ad;
                den = ad*bd;
            end
            FUNC_MUL: begin
                num = an*bn;
                den = ad*bd;
            end
            default: begin
                num = an*bd;
                den = ad*bn;
            end
        endcase
        r.den_zero = (den == 0);
        if (den == 0) den = 1;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        x = nm;
        y = dm;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        neg = (nm != 0) && ((num < 0) != (den < 0));
        r.whole = WHOLE_W'(neg ? -(nm / dm) : (nm / dm));
        r.frac  = FRAC_W'(neg ? -(nm % dm) : (nm % dm));
        r.den   = DEN_W'(dm);
        return r;
    endfunction

    function automatic int rand_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return int'($urandom_range(0, 65535)) - 32768;
            4, 5, 6, 7: return int'($urandom_range(0, 40)) - 20;
            8:          return 0;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return -32768;
                    1:       return 32767;
                    2:       return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    task automatic queue_op(input t_func f, input int an, input int ad, input int bn,
                            input int bd);
        t_operands ops;
        ops.func  = f;
        ops.a_num = 16'(an);
        ops.a_den = 16'(ad);
        ops.b_num = 16'(bn);
        ops.b_den = 16'(bd);
        operand_q.push_back(ops);
    endtask

    // sender: valid held until the item is taken, gaps only between items
    always @(negedge i_clk) begin : drive_blk
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (op_took) void'(operand_q.pop_front());
            if (!i_s_tvalid || op_took) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (operand_q.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else if (ops_taken + CALM_ITEMS < total_ops && $urandom_range(0, 7) == 0) begin
                    tx_gap = $urandom_range(0, 15);
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {operand_q[0].b_den, operand_q[0].b_num,
                                   operand_q[0].a_den, operand_q[0].a_num};
                    i_s_tuser  <= operand_q[0].func;
                end
            end
        end
    end

    // receiver: random stalls, long hold-off when requested
    always @(negedge i_clk) begin : ready_blk
        if (!i_rst_n || hold_left != 0) begin
            i_m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_tready <= 1'b0;
        end else if (results_taken + CALM_ITEMS < total_ops && $urandom_range(0, 5) == 0) begin
            rx_stall = $urandom_range(0, 15);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : hold_blk
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_stage <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_stage < 2 && results_taken >= 30 + hold_stage*450) begin
            hold_left  <= HOLD_CYCLES;
            hold_stage <= hold_stage + 1;
        end
    end

    always @(posedge i_clk) begin : check_blk
        t_operands taken;
        t_mixed    want, got;
        op_took      <= i_rst_n && i_s_tvalid && o_s_tready;
        quiet_cycles <= (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                        ? 0 : quiet_cycles + 1;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            taken.func  = t_func'(i_s_tuser);
            taken.a_num = i_s_tdata[0*OW +: OW];
            taken.a_den = i_s_tdata[1*OW +: OW];
            taken.b_num = i_s_tdata[2*OW +: OW];
            taken.b_den = i_s_tdata[3*OW +: OW];
            quotient_q.push_back(reduce_rational(taken));
            ops_taken <= ops_taken + 1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.whole    = o_m_tdata[0 +: WHOLE_W];
            got.frac     = o_m_tdata[WHOLE_W +: FRAC_W];
            got.den      = o_m_tdata[WHOLE_W+FRAC_W +: DEN_W];
            got.den_zero = o_m_tuser[0];
            results_taken <= results_taken + 1;
            if (quotient_q.size() == 0) begin
                $error("result item with nothing expected: whole_part %0d", got.whole);
                err_cnt++;
            end else begin
                want = quotient_q.pop_front();
                if (got.whole !== want.whole) begin
                    $error("whole_part: expected %0d, got %0d", want.whole, got.whole);
                    err_cnt++;
                end
                if (got.frac !== want.frac) begin
                    $error("frac_num: expected %0d, got %0d", want.frac, got.frac);
                    err_cnt++;
                end
                if (got.den !== want.den) begin
                    $error("red_den: expected %0d, got %0d", want.den, got.den);
                    err_cnt++;
                end
                if (got.den_zero !== want.den_zero) begin
                    $error("den_was_zero: expected %0d, got %0d", want.den_zero, got.den_zero);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main
        int k;
        queue_op(FUNC_ADD, 1, 2, 1, 3);
        queue_op(FUNC_SUB, 1, 2, 1, 3);
        queue_op(FUNC_MUL, -3, 4, 2, -9);
        queue_op(FUNC_DIV, 7, 3, -2, 5);
        queue_op(FUNC_ADD, 0, 5, 0, 7);
        // zero denominators read as one
        queue_op(FUNC_MUL, 5, 0, 3, 0);
        // division by a zero numerator
        queue_op(FUNC_DIV, 5, 3, 0, 7);
        queue_op(FUNC_DIV, 0, 0, 0, 0);
        queue_op(FUNC_DIV, -7, 3, 0, -2);
        queue_op(FUNC_ADD, -32768, 1, -32768, 1);
        queue_op(FUNC_ADD, 32767, 1, 32767, 1);
        queue_op(FUNC_SUB, 32767, 1, -32768, 1);
        queue_op(FUNC_MUL, -32768, 1, -32768, 1);
        queue_op(FUNC_DIV, 1, -32768, -32768, 1);
        queue_op(FUNC_MUL, 1, -32768, 1, 32767);
        queue_op(FUNC_ADD, -32768, 32767, -32768, 32767);
        queue_op(FUNC_SUB, 5, -7, 5, -7);
        queue_op(FUNC_DIV, 6, 4, 3, 2);
        queue_op(FUNC_MUL, -1, -1, -1, -1);
        queue_op(FUNC_ADD, 7, -2, 0, 1);
        queue_op(FUNC_SUB, -32768, -32768, 32767, -32768);
        queue_op(FUNC_DIV, 32767, -32768, 32767, -32768);
        queue_op(FUNC_MUL, -32768, -1, -1, -32768);
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            queue_op(t_func'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                     rand_operand(), rand_operand());
        end
        total_ops = operand_q.size();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (ops_taken < total_ops || quotient_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
